>>> hdl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache package
// Widths, operation codes and the table entry layout of the ARP cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam int OP_W      = 2;
	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int STAMP_W   = 32;
	localparam int TMO_W     = 16;
	localparam int SLOT_W    = 6;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 56;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd300;

	typedef enum logic [OP_W-1:0] {
		OP_LEARN  = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef struct packed {
		logic [IP_W-1:0]    ip;
		logic [MAC_W-1:0]   mac;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

>>> hdl/arp_cache_learn_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache with learning, lookup and aging
// Maps IPv4 addresses to MAC addresses in a table memory scanned linearly.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Content
//  s_axis    in         s_axis_tvalid/s_axis_tready  op, ip_addr, mac_addr
//  m_axis    out        m_axis_tvalid/m_axis_tready  hit, mac_out, slot
//  cfg       in         cfg_valid/cfg_ready          timeout_seconds
//
//  A learn scans the table and then writes one entry, a lookup only scans it;
//  a tick or an ignored item goes straight to its result, one item at a time.
//  The table memory has one read port, so a scan reads one entry per cycle.
//  After reset a clearing pass writes zero to every entry, while no item is
//  taken; configuration writes are taken at all times.
//  A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module arp_cache_learn_lookup_top
	import arpc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// ip_addr [31:0], mac_addr [79:32]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// op [1:0]
	input  logic [OP_W-1:0]      s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// mac_out [47:0], slot [53:48], zero [55:54]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// hit [0]
	output logic                 m_axis_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TMO_W-1:0]     cfg_data
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_RESULT
	} state_t;

	entry_t mem [ENTRIES];

	state_t             state_q;
	op_t                op_q;
	logic [IP_W-1:0]    key_ip_q;
	logic [MAC_W-1:0]   key_mac_q;
	logic [STAMP_W-1:0] now_q;
	logic [TMO_W-1:0]   timeout_q;
	logic [IW-1:0]      cnt_q;
	logic               iss_done_q;

	logic               cmp_vld_s1;
	logic               cmp_last_s1;
	logic [IW-1:0]      cmp_idx_s1;
	entry_t             rd_data_s1;

	logic               found_q;
	logic [IW-1:0]      match_idx_q;
	logic [MAC_W-1:0]   match_mac_q;
	logic               empty_q;
	logic [IW-1:0]      empty_idx_q;
	logic [STAMP_W-1:0] best_age_q;
	logic [IW-1:0]      old_idx_q;
	logic [SLOT_W-1:0]  res_slot_q;

	logic               rd_en;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic [STAMP_W-1:0] age;
	logic               hit_cond;
	logic               is_empty;
	logic               older;
	logic [IW-1:0]      target;
	logic [OP_W-1:0]    in_op;
	logic [IP_W-1:0]    in_ip;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_op         = s_axis_tuser;
	assign in_ip         = s_axis_tdata[IP_W-1:0];

	assign rd_en    = (state_q == ST_SCAN) && !iss_done_q;
	assign age      = now_q - rd_data_s1.stamp;
	assign hit_cond = (rd_data_s1.ip == key_ip_q) &&
		((op_q == OP_LEARN) || (age < STAMP_W'(timeout_q)));
	assign is_empty = (rd_data_s1.ip == '0);
	assign older    = (cmp_idx_s1 == '0) || (age > best_age_q);
	assign target   = found_q ? match_idx_q : (empty_q ? empty_idx_q : old_idx_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = target;
				mem_wdata = '{ip: key_ip_q, mac: key_mac_q, stamp: now_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			op_q          <= OP_TICK;
			key_ip_q      <= '0;
			key_mac_q     <= '0;
			now_q         <= '0;
			timeout_q     <= TIMEOUT_RST;
			cnt_q         <= '0;
			iss_done_q    <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			cmp_last_s1   <= 1'b0;
			cmp_idx_s1    <= '0;
			found_q       <= 1'b0;
			match_idx_q   <= '0;
			match_mac_q   <= '0;
			empty_q       <= 1'b0;
			empty_idx_q   <= '0;
			best_age_q    <= '0;
			old_idx_q     <= '0;
			res_slot_q    <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_RESULT)) begin
				m_axis_tvalid <= 1'b0;
			end

			cmp_vld_s1  <= rd_en;
			cmp_last_s1 <= rd_en && (cnt_q == LAST);
			cmp_idx_s1  <= cnt_q;

			if (cmp_vld_s1) begin
				if (!found_q && hit_cond) begin
					found_q     <= 1'b1;
					match_idx_q <= cmp_idx_s1;
					match_mac_q <= rd_data_s1.mac;
				end
				if (!empty_q && is_empty) begin
					empty_q     <= 1'b1;
					empty_idx_q <= cmp_idx_s1;
				end
				if (older) begin
					best_age_q <= age;
					old_idx_q  <= cmp_idx_s1;
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						key_ip_q   <= in_ip;
						key_mac_q  <= s_axis_tdata[S_TDATA_W-1:IP_W];
						found_q    <= 1'b0;
						empty_q    <= 1'b0;
						res_slot_q <= '0;
						cnt_q      <= '0;
						iss_done_q <= 1'b0;
						state_q    <= ST_RESULT;
						case (in_op)
							OP_LEARN: begin
								op_q <= OP_LEARN;
								if (in_ip != '0) begin
									state_q <= ST_SCAN;
								end
							end
							OP_LOOKUP: begin
								op_q <= OP_LOOKUP;
								if (in_ip != '0) begin
									state_q <= ST_SCAN;
								end
							end
							OP_TICK: begin
								op_q  <= OP_TICK;
								now_q <= now_q + 1'b1;
							end
							default: begin
								op_q <= OP_TICK;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						if (cnt_q == LAST) begin
							iss_done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (cmp_vld_s1 && cmp_last_s1) begin
						state_q <= (op_q == OP_LEARN) ? ST_WRITE : ST_RESULT;
					end
				end
				ST_WRITE: begin
					res_slot_q <= SLOT_W'(target);
					state_q    <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser  <= found_q;
						if (op_q == OP_LEARN) begin
							m_axis_tdata <= {2'b00, res_slot_q, {MAC_W{1'b0}}};
						end else if (found_q) begin
							m_axis_tdata <= {2'b00, SLOT_W'(match_idx_q), match_mac_q};
						end else begin
							m_axis_tdata <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_result_from_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_RESULT))
		else $error("output item appeared outside the result state");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_vld_s1 && cmp_last_s1) |=> !cmp_vld_s1)
		else $error("table read issued after the last entry of a scan");

	a_learn_overwrites_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && found_q) |-> (mem_waddr == match_idx_q))
		else $error("learn did not overwrite the matching entry");

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !(m_axis_tvalid && $rose(m_axis_tvalid)))
		else $error("result produced during the clearing pass");

endmodule

>>> tb/tb_arp_cache_learn_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache testbench
// Drives learn, lookup, tick and unused operations into the cache, keeps its
// own table of IP, MAC and age stamp to work out the reply to every item, and
// checks each reply field by field under varied timeouts, idle patterns and
// output back-pressure.
// ----------------------------------------------------------------------------
module tb_arp_cache_learn_lookup_top;
	import arpc_pkg::*;

	localparam int N_ENTRIES = ENTRIES_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int IP_POOL = 96;
	localparam int SETTLE = N_ENTRIES + 8;

	typedef struct packed {
		logic               hit;
		logic [MAC_W-1:0]   mac;
		logic [SLOT_W-1:0]  slot;
	} arp_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [OP_W-1:0]      s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [TMO_W-1:0]     cfg_data = '0;

	logic [IP_W-1:0]    tbl_ip [N_ENTRIES];
	logic [MAC_W-1:0]   tbl_mac [N_ENTRIES];
	logic [STAMP_W-1:0] tbl_stamp [N_ENTRIES];
	logic [STAMP_W-1:0] now_sec = '0;
	logic [TMO_W-1:0]   timeout_sec = TIMEOUT_RST;

	arp_reply_t      pending_replies [$];
	logic [IP_W-1:0] ip_pool [IP_POOL];
	logic [IP_W-1:0] last_learned = '0;
	int              mismatch_count = 0;
	int              tx_idle_pct = 0;
	int              rx_idle_pct = 0;
	int              rx_hold_request = 0;
	int              rx_hold_left = 0;

	arp_cache_learn_lookup_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic arp_reply_t arp_predict(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
			logic [MAC_W-1:0] mac);
		arp_reply_t r;
		int target;
		bit found;
		bit empty;
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] oldest;
		r = '0;
		target = 0;
		found = 1'b0;
		empty = 1'b0;
		oldest = '0;
		case (op)
		OP_LEARN: begin
			if (ip != '0) begin
				for (int i = 0; i < N_ENTRIES; i++)
					if (!found && tbl_ip[i] == ip) begin
						target = i;
						found = 1'b1;
					end
				for (int i = 0; i < N_ENTRIES; i++)
					if (!found && !empty && tbl_ip[i] == '0) begin
						target = i;
						empty = 1'b1;
					end
				if (!found && !empty) begin
					for (int i = 0; i < N_ENTRIES; i++) begin
						age = now_sec - tbl_stamp[i];
						if (i == 0 || age > oldest) begin
							oldest = age;
							target = i;
						end
					end
				end
				tbl_ip[target] = ip;
				tbl_mac[target] = mac;
				tbl_stamp[target] = now_sec;
				r.hit = found;
				r.slot = SLOT_W'(target);
			end
		end
		OP_LOOKUP: begin
			if (ip != '0) begin
				for (int i = 0; i < N_ENTRIES; i++) begin
					age = now_sec - tbl_stamp[i];
					if (!r.hit && tbl_ip[i] == ip && age < {16'd0, timeout_sec}) begin
						r.hit = 1'b1;
						r.mac = tbl_mac[i];
						r.slot = SLOT_W'(i);
					end
				end
			end
		end
		OP_TICK: now_sec = now_sec + 1'b1;
		default: ;
		endcase
		return r;
	endfunction

	// Inputs change on the falling edge; a call leaves tvalid high after the
	// accepting edge so that back-to-back items keep it up without a glitch.
	task automatic send_op(logic [OP_W-1:0] op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
		int gap;
		gap = 0;
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct && gap < 40)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {mac, ip};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		pending_replies.push_back(arp_predict(op, ip, mac));
		if (op == OP_LEARN && ip != '0)
			last_learned = ip;
	endtask

	task automatic drain_replies(int extra);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_timeout(logic [TMO_W-1:0] value);
		drain_replies(8);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		timeout_sec = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_hold_request > 0) begin
			rx_hold_left = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin : reply_check
		arp_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				$error("reply with no item outstanding: hit %0b mac %h slot %0d",
					m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[53:48]);
				mismatch_count++;
			end else begin
				want = pending_replies.pop_front();
				if (m_axis_tuser !== want.hit) begin
					$error("hit: expected %0b, actual %0b", want.hit, m_axis_tuser);
					mismatch_count++;
				end
				if (m_axis_tdata[47:0] !== want.mac) begin
					$error("mac_out: expected %h, actual %h", want.mac, m_axis_tdata[47:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[53:48] !== want.slot) begin
					$error("slot: expected %0d, actual %0d", want.slot, m_axis_tdata[53:48]);
					mismatch_count++;
				end
			end
		end
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return wide[MAC_W-1:0];
	endfunction

	function automatic logic [IP_W-1:0] rand_ip();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 15)
			return $urandom;
		return ip_pool[$urandom_range(IP_POOL - 1)];
	endfunction

	task automatic test_empty_table();
		send_op(OP_LOOKUP, 32'h0a00_0001, '0);
		send_op(OP_LOOKUP, '0, rand_mac());
		send_op(OP_LEARN, '0, {MAC_W{1'b1}});
		send_op(OP_LOOKUP, '0, '0);
		send_op(OP_TICK, 32'hffff_ffff, {MAC_W{1'b1}});
		send_op(OP_UNUSED, 32'h0a00_0001, rand_mac());
	endtask

	task automatic test_learn_and_lookup();
		send_op(OP_LEARN, 32'hffff_ffff, {MAC_W{1'b1}});
		send_op(OP_LEARN, 32'h0000_0001, '0);
		send_op(OP_LOOKUP, 32'hffff_ffff, '0);
		send_op(OP_LOOKUP, 32'h0000_0001, {MAC_W{1'b1}});
		send_op(OP_LEARN, 32'hffff_ffff, 48'h0123_4567_89ab);
		send_op(OP_LOOKUP, 32'hffff_ffff, '0);
		send_op(OP_LOOKUP, 32'h0000_0002, '0);
	endtask

	// An entry answers while its age is below the timeout, a relearn refreshes
	// a stale entry, a zero timeout never answers.
	task automatic test_aging_and_timeout();
		write_timeout(16'd2);
		send_op(OP_LEARN, 32'hc0a8_0101, 48'haaaa_5555_aaaa);
		send_op(OP_LOOKUP, 32'hc0a8_0101, '0);
		send_op(OP_TICK, '0, '0);
		send_op(OP_LOOKUP, 32'hc0a8_0101, '0);
		send_op(OP_TICK, '0, '0);
		send_op(OP_LOOKUP, 32'hc0a8_0101, '0);
		send_op(OP_LEARN, 32'hc0a8_0101, 48'h5555_aaaa_5555);
		send_op(OP_LOOKUP, 32'hc0a8_0101, '0);
		write_timeout(16'd0);
		send_op(OP_LOOKUP, 32'hc0a8_0101, '0);
		write_timeout(16'hffff);
		send_op(OP_TICK, '0, '0);
		send_op(OP_LOOKUP, 32'hc0a8_0101, '0);
	endtask

	task automatic test_backpressure();
		rx_hold_request = 600;
		for (int i = 0; i < 12; i++)
			send_op(i[0] ? OP_LOOKUP : OP_LEARN, ip_pool[i], rand_mac());
		drain_replies(SETTLE);
	endtask

	task automatic test_random_traffic(int tx_pct, int rx_pct, logic [TMO_W-1:0] tmo, int count);
		int done;
		int pick;
		logic [OP_W-1:0] op;
		logic [IP_W-1:0] ip;
		done = 0;
		write_timeout(tmo);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		while (done < count) begin
			pick = $urandom_range(99);
			op = pick < 45 ? OP_LEARN : pick < 85 ? OP_LOOKUP : pick < 98 ? OP_TICK : OP_UNUSED;
			ip = rand_ip();
			if (op == OP_LOOKUP && $urandom_range(99) < 40)
				ip = last_learned;
			send_op(op, ip, rand_mac());
			if (op != OP_UNUSED && !(op == OP_LEARN && ip == '0))
				done++;
			if (done == count / 2 && tx_pct > 0)
				drain_replies(0);
		end
		drain_replies(SETTLE);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
	endtask

	initial begin
		for (int i = 0; i < N_ENTRIES; i++) begin
			tbl_ip[i] = '0;
			tbl_mac[i] = '0;
			tbl_stamp[i] = '0;
		end
		ip_pool[0] = 32'hffff_ffff;
		ip_pool[1] = 32'h0000_0001;
		for (int i = 2; i < IP_POOL; i++)
			ip_pool[i] = $urandom | 32'h1;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_learn_and_lookup();
		test_aging_and_timeout();
		drain_replies(SETTLE);
		test_backpressure();
		test_random_traffic(0, 0, 16'd5, 200);
		test_random_traffic(46, 0, 16'd17, 200);
		test_random_traffic(0, 46, 16'd1, 200);
		test_random_traffic(9, 9, 16'hffff, 200);
		test_random_traffic(0, 0, 16'd300, 200);

		drain_replies(SETTLE);
		if (mismatch_count == 0 && pending_replies.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
